@@ rtl/max_pooling_argmax_unit_macros.svh @@
// assertion macros used by the port-level checker
`ifndef MAX_POOLING_ARGMAX_UNIT_MACROS_SVH
`define MAX_POOLING_ARGMAX_UNIT_MACROS_SVH

// same-cycle implication, masked while reset is low
`define MPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while reset is low
`define MPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also checks across the reset edge
`define MPA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mpa_pkg.sv @@
// shared types and constants of the max pooling argmax unit
`timescale 1ns / 1ps

package mpa_pkg;

  localparam int OCOL_W = 10;
  localparam int ROW_W  = 12;
  localparam int CHAN_W = 12;
  localparam int OFF_W  = 4;
  localparam int CFG_AW = 5;

  localparam logic [12:0] MAX_ROWS  = 13'd4096;
  localparam logic [12:0] MAX_CHANS = 13'd4096;

  typedef enum logic [2:0] {
    REG_IN_WIDTH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_CHANNELS    = 3'd2,
    REG_POOL_WIDTH  = 3'd3,
    REG_POOL_HEIGHT = 3'd4
  } reg_idx_t;

  // effective (clamped) frame geometry
  typedef struct packed {
    logic [10:0] width;
    logic [12:0] height;
    logic [12:0] chans;
    logic [4:0]  pool_w;
    logic [4:0]  pool_h;
  } dims_t;

  // position info of one pixel, carried into the update stage
  typedef struct packed {
    logic [OCOL_W-1:0] ocol;
    logic [ROW_W-1:0]  orow;
    logic [CHAN_W-1:0] chan;
    logic [OCOL_W-1:0] cbase;
    logic [ROW_W-1:0]  rbase;
    logic [OFF_W-1:0]  dx;
    logic [OFF_W-1:0]  dy;
    logic              first;
    logic              emit;
    logic              done;
  } pos_t;

endpackage

@@ rtl/mpa_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module mpa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mpa_cfg.sv @@
// configuration registers, apb access and geometry clamping
`timescale 1ns / 1ps

module mpa_cfg #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_POOL  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mpa_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      restart,
  output mpa_pkg::dims_t            dims
);
  import mpa_pkg::*;

  logic [10:0] in_width_r, in_width_nxt;
  logic [12:0] in_height_r, in_height_nxt;
  logic [12:0] chans_r, chans_nxt;
  logic [4:0]  pool_w_r, pool_w_nxt;
  logic [4:0]  pool_h_r, pool_h_nxt;
  logic        wr;
  reg_idx_t    idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_comb begin
    in_width_nxt  = in_width_r;
    in_height_nxt = in_height_r;
    chans_nxt     = chans_r;
    pool_w_nxt    = pool_w_r;
    pool_h_nxt    = pool_h_r;
    restart       = 1'b0;
    if (wr) begin
      case (idx)
        REG_IN_WIDTH: begin
          in_width_nxt = pwdata[10:0];
          restart      = 1'b1;
        end
        REG_IN_HEIGHT: begin
          in_height_nxt = pwdata[12:0];
          restart       = 1'b1;
        end
        REG_CHANNELS: begin
          chans_nxt = pwdata[12:0];
          restart   = 1'b1;
        end
        REG_POOL_WIDTH: begin
          pool_w_nxt = pwdata[4:0];
          restart    = 1'b1;
        end
        REG_POOL_HEIGHT: begin
          pool_h_nxt = pwdata[4:0];
          restart    = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= 11'd32;
      in_height_r <= 13'd32;
      chans_r     <= 13'd1;
      pool_w_r    <= 5'd2;
      pool_h_r    <= 5'd2;
    end else begin
      in_width_r  <= in_width_nxt;
      in_height_r <= in_height_nxt;
      chans_r     <= chans_nxt;
      pool_w_r    <= pool_w_nxt;
      pool_h_r    <= pool_h_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_IN_WIDTH:    prdata = 32'(in_width_r);
      REG_IN_HEIGHT:   prdata = 32'(in_height_r);
      REG_CHANNELS:    prdata = 32'(chans_r);
      REG_POOL_WIDTH:  prdata = 32'(pool_w_r);
      REG_POOL_HEIGHT: prdata = 32'(pool_h_r);
      default:         prdata = 32'd0;
    endcase
  end

  // zero acts as one, oversize saturates
  always_comb begin
    dims.width = (in_width_r == '0) ? 11'd1 :
                 (32'(in_width_r) > MAX_WIDTH) ? 11'(MAX_WIDTH) : in_width_r;
    dims.height = (in_height_r == '0) ? 13'd1 :
                  (in_height_r > MAX_ROWS) ? MAX_ROWS : in_height_r;
    dims.chans = (chans_r == '0) ? 13'd1 :
                 (chans_r > MAX_CHANS) ? MAX_CHANS : chans_r;
    dims.pool_w = (pool_w_r == '0) ? 5'd1 :
                  (32'(pool_w_r) > MAX_POOL) ? 5'(MAX_POOL) : pool_w_r;
    dims.pool_h = (pool_h_r == '0) ? 5'd1 :
                  (32'(pool_h_r) > MAX_POOL) ? 5'(MAX_POOL) : pool_h_r;
  end

endmodule

@@ rtl/mpa_pos.sv @@
// raster position sequencer: pixel, window and output coordinates
`timescale 1ns / 1ps

module mpa_pos #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_POOL  = 16
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 restart,
  input  logic                                                 advance,
  input  mpa_pkg::dims_t                                       dims,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] addr,
  output mpa_pkg::pos_t                                        pos
);
  import mpa_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int OW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

  logic [CW-1:0]     col_r, col_nxt, oc_r, oc_nxt;
  logic [OW-1:0]     wco_r, wco_nxt, wro_r, wro_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt, orow_r, orow_nxt, rbase_r, rbase_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic [OCOL_W-1:0] cbase_r, cbase_nxt;
  logic              last_col, last_row, last_chan, wco_end, wro_end;

  assign last_col  = (32'(col_r) + 32'd1 == 32'(dims.width));
  assign last_row  = (32'(row_r) + 32'd1 == 32'(dims.height));
  assign last_chan = (32'(chan_r) + 32'd1 == 32'(dims.chans));
  assign wco_end   = (32'(wco_r) + 32'd1 == 32'(dims.pool_w));
  assign wro_end   = (32'(wro_r) + 32'd1 == 32'(dims.pool_h));

  assign addr      = oc_r;
  assign pos.ocol  = OCOL_W'(oc_r);
  assign pos.orow  = orow_r;
  assign pos.chan  = chan_r;
  assign pos.cbase = cbase_r;
  assign pos.rbase = rbase_r;
  assign pos.dx    = OFF_W'(wco_r);
  assign pos.dy    = OFF_W'(wro_r);
  assign pos.first = (wco_r == '0) && (wro_r == '0);
  assign pos.emit  = (wco_end || last_col) && (wro_end || last_row);
  assign pos.done  = last_col && last_row && last_chan;

  always_comb begin
    col_nxt   = col_r;
    oc_nxt    = oc_r;
    wco_nxt   = wco_r;
    cbase_nxt = cbase_r;
    row_nxt   = row_r;
    wro_nxt   = wro_r;
    orow_nxt  = orow_r;
    rbase_nxt = rbase_r;
    chan_nxt  = chan_r;
    if (restart) begin
      col_nxt   = '0;
      oc_nxt    = '0;
      wco_nxt   = '0;
      cbase_nxt = '0;
      row_nxt   = '0;
      wro_nxt   = '0;
      orow_nxt  = '0;
      rbase_nxt = '0;
      chan_nxt  = '0;
    end else if (advance) begin
      if (last_col) begin
        col_nxt   = '0;
        oc_nxt    = '0;
        wco_nxt   = '0;
        cbase_nxt = '0;
        if (last_row) begin
          row_nxt   = '0;
          wro_nxt   = '0;
          orow_nxt  = '0;
          rbase_nxt = '0;
          chan_nxt  = last_chan ? '0 : chan_r + 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
          if (wro_end) begin
            wro_nxt   = '0;
            orow_nxt  = orow_r + 1'b1;
            rbase_nxt = row_r + 1'b1;
          end else begin
            wro_nxt = wro_r + 1'b1;
          end
        end
      end else begin
        col_nxt = col_r + 1'b1;
        if (wco_end) begin
          wco_nxt   = '0;
          oc_nxt    = oc_r + 1'b1;
          cbase_nxt = OCOL_W'(col_r) + 10'd1;
        end else begin
          wco_nxt = wco_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      oc_r    <= '0;
      wco_r   <= '0;
      cbase_r <= '0;
      row_r   <= '0;
      wro_r   <= '0;
      orow_r  <= '0;
      rbase_r <= '0;
      chan_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      oc_r    <= oc_nxt;
      wco_r   <= wco_nxt;
      cbase_r <= cbase_nxt;
      row_r   <= row_nxt;
      wro_r   <= wro_nxt;
      orow_r  <= orow_nxt;
      rbase_r <= rbase_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

@@ rtl/max_pooling_argmax_unit.sv @@
// top level: max pooling with argmax over a streamed feature map
// Pixels enter on the in_ stream in raster order, one channel plane after
// another; in_tdata carries one signed Q8.8 sample. When a pixel closes a
// pooling window, one request leaves on the out_ stream with the window
// maximum, its output coordinates, the channel and the input column and row
// of the maximum; out_tlast marks the last window of the last channel.
// Geometry is set through the cfg_ apb port; a write to any defined register
// restarts the frame at column, row and channel zero.
// A result is registered in the update stage and then in the output register
// before out_tvalid shows it. Throughput: one pixel per cycle, held up only
// by the output. The per-column partial maxima sit in one ram that is read
// as a pixel is taken, alongside its update stage register; consecutive
// pixels of the same window are served by a bypass of the previous write.
// Reset clears the position counters, the pipeline and the output stage;
// the ram is not cleared, since every window writes its entry on its first
// pixel. When the receiver stalls, an output register plus a skid entry
// absorb the results in flight; in_tready drops once both are full while a
// pixel waits in the update stage.
`timescale 1ns / 1ps

module max_pooling_argmax_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_POOL  = 16,
  parameter int DATA_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // pixel [DATA_BITS-1:0]
  input  logic [((DATA_BITS + 7) / 8) * 8 - 1:0]   in_tdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // max_value, out_col, out_row, channel, argmax_col, argmax_row
  output logic [((DATA_BITS + 63) / 8) * 8 - 1:0]  out_tdata,
  output logic                                     out_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  input  logic                                     cfg_psel,
  input  logic                                     cfg_penable,
  input  logic                                     cfg_pwrite,
  input  logic [mpa_pkg::CFG_AW-1:0]               cfg_paddr,
  input  logic [31:0]                              cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);
  import mpa_pkg::*;

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int OUT_W = ((DATA_BITS + 63) / 8) * 8;
  localparam int ENT_W = DATA_BITS + 2 * OFF_W;

  dims_t                 dims;
  pos_t                  pos;
  logic                  restart;
  logic [AW-1:0]         pos_addr;
  logic                  accept;

  logic                  s1_valid_r, s1_valid_nxt;
  pos_t                  s1_pos_r;
  logic [DATA_BITS-1:0]  s1_px_r;
  logic [AW-1:0]         s1_addr_r;
  logic                  fwd_hit_r;
  logic [ENT_W-1:0]      fwd_data_r;
  logic                  s1_go, s1_fire, push, take;
  logic [ENT_W-1:0]      rd_data, stored, wr_data;
  logic [DATA_BITS-1:0]  new_max;
  logic [OFF_W-1:0]      new_dx, new_dy;
  logic [OCOL_W-1:0]     arg_col;
  logic [ROW_W-1:0]      arg_row;
  logic [OUT_W-1:0]      res_data;

  logic                  out_valid_r, out_valid_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic                  out_last_r, out_last_nxt, skid_last_r, skid_last_nxt;

  assign cfg_pready = 1'b1;

  mpa_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_POOL  (MAX_POOL)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .restart (restart),
    .dims    (dims)
  );

  mpa_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_POOL  (MAX_POOL)
  ) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .advance (accept),
    .dims    (dims),
    .addr    (pos_addr),
    .pos     (pos)
  );

  // entry layout: {max, dx, dy}
  mpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_addr_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (pos_addr),
    .rdata (rd_data)
  );

  assign s1_go     = !skid_valid_r;
  assign s1_fire   = s1_valid_r && s1_go;
  assign in_tready = !s1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  assign s1_valid_nxt = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  // the ram read and a write to the same entry share an edge: bypass it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r   <= pos;
      s1_px_r    <= in_tdata[DATA_BITS-1:0];
      s1_addr_r  <= pos_addr;
      fwd_hit_r  <= s1_fire && (s1_addr_r == pos_addr);
      fwd_data_r <= wr_data;
    end
  end

  // strict compare keeps the earliest pixel on ties
  assign stored  = fwd_hit_r ? fwd_data_r : rd_data;
  assign take    = s1_pos_r.first ||
                   ($signed(s1_px_r) > $signed(stored[ENT_W-1:2*OFF_W]));
  assign wr_data = take ? {s1_px_r, s1_pos_r.dx, s1_pos_r.dy} : stored;
  assign new_max = wr_data[ENT_W-1:2*OFF_W];
  assign new_dx  = wr_data[2*OFF_W-1:OFF_W];
  assign new_dy  = wr_data[OFF_W-1:0];
  assign arg_col = s1_pos_r.cbase + OCOL_W'(new_dx);
  assign arg_row = s1_pos_r.rbase + ROW_W'(new_dy);
  assign res_data = OUT_W'({arg_row, arg_col, s1_pos_r.chan, s1_pos_r.orow,
                            s1_pos_r.ocol, new_max});
  assign push    = s1_fire && s1_pos_r.emit;

  // output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_last_nxt  = skid_last_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = res_data;
        out_last_nxt  = s1_pos_r.done;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
      skid_last_nxt  = s1_pos_r.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    skid_data_r <= skid_data_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/mpa_checker.sv @@
// port-level checks of the max pooling argmax unit, bound to the top level
`timescale 1ns / 1ps
`include "max_pooling_argmax_unit_macros.svh"

module mpa_checker #(
  parameter int DATA_BITS = 16
) (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_tready,
  input logic                                    out_tvalid,
  input logic                                    out_tready,
  input logic [((DATA_BITS + 63) / 8) * 8 - 1:0] out_tdata,
  input logic                                    out_tlast
);

  // pipeline and output stage come out of reset empty
  `MPA_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid && in_tready, "not empty after reset")

  // input backpressure only follows an output stall
  `MPA_ASSERT_IMP(a_stall_cause, !in_tready, $past(out_tvalid && !out_tready), "stall without cause")

  // a held request keeps its payload
  `MPA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed under stall")

  // no backpressure while the output side is free
  `MPA_ASSERT_IMP(a_no_false_stall, !out_tvalid, in_tready, "stall with empty output")

endmodule

bind max_pooling_argmax_unit mpa_checker #(
  .DATA_BITS (DATA_BITS)
) u_mpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ dv/max_pool_checker.sv @@
// checker for the max pooling argmax unit: predicts each window result and compares it
`timescale 1ns / 1ps

module max_pool_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [15:0]                in_tdata,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [71:0]                out_tdata,
  input  logic                       out_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [mpa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         fail_count,
  output int                         pending
);
  import mpa_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_POOL  = 16;

  typedef struct packed {
    logic [15:0] max_value;
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic [11:0] chan;
    logic [9:0]  arg_col;
    logic [11:0] arg_row;
    logic        frame_done;
  } window_t;

  // geometry as written
  logic [10:0] geo_w;
  logic [12:0] geo_h;
  logic [12:0] geo_c;
  logic [4:0]  geo_pw;
  logic [4:0]  geo_ph;

  // per output column partial maximum and its offset inside the window
  logic signed [15:0] col_max [MAX_WIDTH];
  logic [3:0]         col_dx  [MAX_WIDTH];
  logic [3:0]         col_dy  [MAX_WIDTH];

  logic [9:0]  col_pos;
  logic [11:0] row_pos;
  logic [11:0] chan_pos;
  logic [3:0]  off_x;
  logic [3:0]  off_y;

  window_t window_q[$];
  int      errs = 0;

  function automatic int clamp_dim(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame();
    col_pos  = '0;
    row_pos  = '0;
    chan_pos = '0;
    off_x    = '0;
    off_y    = '0;
  endtask

  task automatic predict_window(input logic signed [15:0] px);
    int      w, h, nc, pw, ph;
    int      col, row, chan, dx, dy, oc, orow, slot;
    bit      last_col, last_row;
    window_t r;
    w    = clamp_dim(int'(geo_w), MAX_WIDTH);
    h    = clamp_dim(int'(geo_h), int'(MAX_ROWS));
    nc   = clamp_dim(int'(geo_c), int'(MAX_CHANS));
    pw   = clamp_dim(int'(geo_pw), MAX_POOL);
    ph   = clamp_dim(int'(geo_ph), MAX_POOL);
    col  = int'(col_pos);
    row  = int'(row_pos);
    chan = int'(chan_pos);
    dx   = int'(off_x);
    dy   = int'(off_y);
    if (col >= w) begin
      col = 0;
      dx  = 0;
    end
    if (row >= h) begin
      row = 0;
      dy  = 0;
    end
    if (chan >= nc) chan = 0;
    if (dx >= pw) dx = 0;
    if (dy >= ph) dy = 0;

    oc   = col / pw;
    orow = row / ph;
    slot = oc % MAX_WIDTH;

    // first pixel of a window always opens the entry; later ones must beat it
    if ((dx == 0 && dy == 0) || px > col_max[slot]) begin
      col_max[slot] = px;
      col_dx[slot]  = 4'(dx);
      col_dy[slot]  = 4'(dy);
    end

    last_col = (dx + 1 == pw) || (col + 1 == w);
    last_row = (dy + 1 == ph) || (row + 1 == h);
    if (last_col && last_row) begin
      r.max_value  = col_max[slot];
      r.out_col    = 10'(oc);
      r.out_row    = 12'(orow);
      r.chan       = 12'(chan);
      r.arg_col    = 10'(oc * pw + int'(col_dx[slot]));
      r.arg_row    = 12'(orow * ph + int'(col_dy[slot]));
      r.frame_done = (col + 1 == w) && (row + 1 == h) && (chan + 1 == nc);
      window_q.push_back(r);
    end

    dx++;
    if (dx >= pw) dx = 0;
    col++;
    if (col >= w) begin
      col = 0;
      dx  = 0;
      dy++;
      if (dy >= ph) dy = 0;
      row++;
      if (row >= h) begin
        row = 0;
        dy  = 0;
        chan++;
        if (chan >= nc) chan = 0;
      end
    end
    col_pos  = 10'(col);
    row_pos  = 12'(row);
    chan_pos = 12'(chan);
    off_x    = 4'(dx);
    off_y    = 4'(dy);
  endtask

  always @(posedge clk) begin
    window_t got;
    window_t want;
    bit      hit;
    if (!rst_n) begin
      geo_w  = 11'd32;
      geo_h  = 13'd32;
      geo_c  = 13'd1;
      geo_pw = 5'd2;
      geo_ph = 5'd2;
      restart_frame();
      window_q.delete();
    end else begin
      // results leave only after their pixel has passed the update and output registers, so compare first
      if (out_tvalid && out_tready) begin
        got.max_value  = out_tdata[15:0];
        got.out_col    = out_tdata[25:16];
        got.out_row    = out_tdata[37:26];
        got.chan       = out_tdata[49:38];
        got.arg_col    = out_tdata[59:50];
        got.arg_row    = out_tdata[71:60];
        got.frame_done = out_tlast;
        if (window_q.size() == 0) begin
          if (errs < 10)
            $display("unexpected window: max=%0d col=%0d row=%0d ch=%0d at=(%0d,%0d) last=%0b",
                     $signed(got.max_value), got.out_col, got.out_row, got.chan,
                     got.arg_col, got.arg_row, got.frame_done);
          errs++;
        end else begin
          want = window_q.pop_front();
          if (got !== want) begin
            if (errs < 10) begin
              $display("window mismatch: expected max=%0d col=%0d row=%0d ch=%0d at=(%0d,%0d) last=%0b",
                       $signed(want.max_value), want.out_col, want.out_row, want.chan,
                       want.arg_col, want.arg_row, want.frame_done);
              $display("                 actual   max=%0d col=%0d row=%0d ch=%0d at=(%0d,%0d) last=%0b",
                       $signed(got.max_value), got.out_col, got.out_row, got.chan,
                       got.arg_col, got.arg_row, got.frame_done);
            end
            errs++;
          end
        end
      end

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        hit = 1'b1;
        case (cfg_paddr[CFG_AW-1:2])
          REG_IN_WIDTH:    geo_w  = cfg_pwdata[10:0];
          REG_IN_HEIGHT:   geo_h  = cfg_pwdata[12:0];
          REG_CHANNELS:    geo_c  = cfg_pwdata[12:0];
          REG_POOL_WIDTH:  geo_pw = cfg_pwdata[4:0];
          REG_POOL_HEIGHT: geo_ph = cfg_pwdata[4:0];
          default:         hit    = 1'b0;
        endcase
        // only a real register restarts the frame
        if (hit) restart_frame();
      end

      if (in_tvalid && in_tready) predict_window(in_tdata[15:0]);
    end
    fail_count <= errs;
    pending    <= window_q.size();
  end

endmodule

@@ dv/tb_max_pooling_argmax_unit.sv @@
// testbench top for the max pooling argmax unit: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_max_pooling_argmax_unit;
  import mpa_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd5;  // no register behind this index
  localparam int         LIMIT_NS  = 2_000_000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  // pixel [15:0]
  logic [15:0]       in_tdata = '0;
  logic              in_tvalid = 1'b0;
  wire               in_tready;
  // max_value [15:0], out_col [25:16], out_row [37:26], channel [49:38],
  // argmax_col [59:50], argmax_row [71:60]
  wire  [71:0]       out_tdata;
  wire               out_tlast;
  wire               out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  wire  [31:0]       cfg_prdata;
  wire               cfg_pready;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 38;
  int   recv_idle_pct = 67;
  int   accepted = 0;
  logic hold_go = 1'b0;
  logic stall_out = 1'b0;

  always #4 clk = ~clk;

  max_pooling_argmax_unit dut (.*);

  max_pool_checker checker_i (.*);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !stall_out && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the pipeline and skid fill and in_tready drops
  initial begin
    wait (hold_go);
    @(posedge clk);
    stall_out <= 1'b1;
    repeat (300) @(posedge clk);
    stall_out <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("max_pooling_argmax_unit test failed");
    $finish;
  end

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(2)) - 16'd1;  // narrow range makes ties
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer_pixel(input logic [15:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    accepted++;
  endtask

  // back-to-back writes chain setup right after access; bus drops after the last
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value,
                           input bit final_write);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (final_write) begin
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
    end
  endtask

  task automatic set_geometry(input int w, input int h, input int c, input int pw,
                              input int ph);
    write_reg(REG_IN_WIDTH, 32'(w), 1'b0);
    write_reg(REG_IN_HEIGHT, 32'(h), 1'b0);
    write_reg(REG_CHANNELS, 32'(c), 1'b0);
    write_reg(REG_POOL_WIDTH, 32'(pw), 1'b0);
    write_reg(REG_POOL_HEIGHT, 32'(ph), 1'b1);
  endtask

  // wait until all results are in, then let pixels that close no window drain from the pipeline
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [15:0] ragged_px [9];
    int n, w, h, c, pw, ph, base;

    // 3x3 plane, 2x2 windows: ragged right and bottom, ties, both extremes
    ragged_px = '{16'h0005, 16'h0005, 16'h8000,
                  16'h0005, 16'h0005, 16'h8000,
                  16'hFFFF, 16'h7FFF, 16'h0000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry is 32 wide, so none of these closes a window
    repeat (4) offer_pixel(pick_pixel());
    wait_drained();

    set_geometry(3, 3, 1, 2, 2);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) begin
        // write to an unused index must leave the frame position alone
        wait_drained();
        write_reg(REG_SPARE, 32'hFFFF_FFFF, 1'b1);
      end
      offer_pixel(ragged_px[i]);
    end
    wait_drained();

    // zero in every register acts as one: each pixel is a whole frame
    set_geometry(0, 0, 0, 0, 0);
    offer_pixel(16'h7FFF);
    offer_pixel(16'h8000);
    offer_pixel(16'h0000);

    base = accepted;
    for (int p = 0; accepted - base < 390; p++) begin
      if (accepted - base >= 260) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end else if (accepted - base >= 130) begin
        send_idle_pct = 67;
        recv_idle_pct <= 38;
      end
      wait_drained();
      case (p)
        2: begin
          // oversized values clamp to 1024 wide, 4096 high and deep, 16 pool width
          set_geometry(2047, 8191, 8191, 31, 1);
          n = 48;
        end
        5: begin
          // one column, tall clipped windows: full row offset range
          set_geometry(1, 20, 2, 16, 16);
          n = 40;
        end
        8: begin
          set_geometry(0, 0, 0, 0, 0);
          n = 10;
        end
        11: begin
          set_geometry(1024, 1, 4096, 16, 16);
          n = 48;
        end
        default: begin
          w  = $urandom_range(1, 9);
          h  = $urandom_range(1, 6);
          c  = $urandom_range(1, 3);
          pw = $urandom_range(1, 4);
          ph = $urandom_range(1, 4);
          set_geometry(w, h, c, pw, ph);
          n = w * h * c + $urandom_range(0, 8);
          if (n > 60) n = 60;
        end
      endcase
      repeat (n) offer_pixel(pick_pixel());
    end

    // 1x1 windows give a request per pixel while the receiver holds off
    wait_drained();
    send_idle_pct = 0;
    set_geometry(4, 4, 2, 1, 1);
    hold_go <= 1'b1;
    repeat (32) offer_pixel(pick_pixel());
    wait_drained();

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("max_pooling_argmax_unit test passed");
    end else begin
      $display("max_pooling_argmax_unit test failed");
    end
    $finish;
  end

endmodule
